@@ sv/sle_pkg.sv @@
// Shared types and constants for the sorted list engine.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package sle_pkg;

   localparam int VALUE_W  = 32;
   localparam int POS_W    = 7;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Broadcast from the controller to every cell of the list.
   typedef struct packed {
      logic                       ins_en;
      logic                       rem_en;
      logic signed [VALUE_W-1:0]  new_value;
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ sv/sorted_list_engine.sv @@
// Sorted list engine: a row of cells keeps up to CAPACITY signed entries in ascending order.
// Insert, remove, unused codes and rejected commands answer in the cycle after acceptance,
// so a new transaction can be accepted every cycle while the response register drains.
// A read in range waits in S_READ while the selected value climbs the registered OR tree and
// blocks new transactions meanwhile. Synchronous active-high reset empties the list
// and the response register; the stored values themselves are not cleared.
`default_nettype none

module sorted_list_engine #(
   parameter int CAPACITY = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [sle_pkg::CMD_W-1:0]          req_command,
   input  wire logic signed [sle_pkg::VALUE_W-1:0] req_value,
   input  wire logic [sle_pkg::POS_W-1:0]          req_position,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [sle_pkg::VALUE_W-1:0]      rsp_read_value,
   output logic [sle_pkg::POS_W-1:0]               rsp_count,
   output logic [sle_pkg::STATUS_W-1:0]            rsp_status
);

   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int MW     = (CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W;
   localparam int LEVELS = $clog2(CAPACITY);
   localparam int LEAVES = 2 ** LEVELS;
   localparam int WW     = $clog2(LEVELS + 1);
   localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
   localparam logic [WW-1:0] LEVELS_C = WW'(LEVELS);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type                            state_ff, state_in;
   logic [CW-1:0]                        count_ff, count_in;
   logic [CW-1:0]                        rd_idx_ff, rd_idx_in;
   logic [WW-1:0]                        wait_ff, wait_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [sle_pkg::VALUE_W-1:0]   rsp_read_value_ff, rsp_read_value_in;
   logic [sle_pkg::POS_W-1:0]            rsp_count_ff, rsp_count_in;
   sle_pkg::status_type                  rsp_status_ff, rsp_status_in;

   logic                                 req_accept;
   logic                                 load_rsp;
   sle_pkg::cmd_type                     cmd;
   logic [MW-1:0]                        pos_ext;
   logic [MW-1:0]                        pos_m1;
   logic [MW-1:0]                        count_next_ext;
   logic                                 pos_bad;
   logic                                 full;
   logic [CW-1:0]                        rem_start;
   sle_pkg::cell_ctl_type                ctl;

   logic signed [sle_pkg::VALUE_W-1:0]   cell_value [CAPACITY];
   logic                                 cell_ge [CAPACITY];
   logic [sle_pkg::VALUE_W-1:0]          leaf [LEAVES];
   logic [sle_pkg::VALUE_W-1:0]          tree_root;

   assign req_ready  = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;
   assign cmd        = sle_pkg::cmd_type'(req_command);

   assign pos_ext   = MW'(req_position);
   assign pos_m1    = pos_ext - MW'(1);
   assign rem_start = pos_m1[CW-1:0];
   assign pos_bad   = (req_position == '0) || (pos_ext > MW'(count_ff));
   assign full      = (count_ff == CAP_C);

   assign ctl.ins_en    = req_accept && (cmd == sle_pkg::CMD_INSERT) && !full;
   assign ctl.rem_en    = req_accept && (cmd == sle_pkg::CMD_REMOVE) && !pos_bad;
   assign ctl.new_value = req_value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [sle_pkg::VALUE_W-1:0] left_value;
      logic                                left_ge;
      logic signed [sle_pkg::VALUE_W-1:0] right_value;
      if (i == 0) begin : g_first
         assign left_value = '0;
         assign left_ge    = 1'b0;
      end else begin : g_mid
         assign left_value = cell_value[i - 1];
         assign left_ge    = cell_ge[i - 1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_notlast
         assign right_value = cell_value[i + 1];
      end
      sle_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .count       (count_ff),
         .rem_start   (rem_start),
         .left_value  (left_value),
         .left_ge     (left_ge),
         .right_value (right_value),
         .value       (cell_value[i]),
         .ge          (cell_ge[i])
      );
   end

   // Only the addressed cell can drive a nonzero leaf; the tree ORs them together.
   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < CAPACITY) begin : g_used
         assign leaf[i] = (rd_idx_ff == CW'(i)) ? cell_value[i] : '0;
      end else begin : g_pad
         assign leaf[i] = '0;
      end
   end

   sle_read_tree #(
      .LEAVES (LEAVES)
   ) u_read_tree (
      .clock (clock),
      .leaf  (leaf),
      .root  (tree_root)
   );

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      rd_idx_in         = rd_idx_ff;
      wait_in           = wait_ff;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_status_in     = rsp_status_ff;
      load_rsp          = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rsp_read_value_in = '0;
               rsp_status_in     = sle_pkg::STATUS_OK;
               load_rsp          = 1'b1;
               unique case (cmd)
                  sle_pkg::CMD_INSERT: begin
                     if (full) begin
                        rsp_status_in = sle_pkg::STATUS_FULL;
                     end else begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  sle_pkg::CMD_REMOVE: begin
                     if (pos_bad) begin
                        rsp_status_in = sle_pkg::STATUS_RANGE;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  sle_pkg::CMD_READ: begin
                     if (pos_bad) begin
                        rsp_status_in = sle_pkg::STATUS_RANGE;
                     end else begin
                        load_rsp  = 1'b0;
                        state_in  = S_READ;
                        rd_idx_in = rem_start;
                        wait_in   = LEVELS_C;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - WW'(1);
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_read_value_in = tree_root;
               rsp_status_in     = sle_pkg::STATUS_OK;
               load_rsp          = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      count_next_ext = MW'(count_in);
      rsp_count_in   = load_rsp ? count_next_ext[sle_pkg::POS_W-1:0] : rsp_count_ff;
      rsp_valid_in   = load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff         <= rd_idx_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

@@ sv/sle_cell.sv @@
// One storage cell of the sorted list: holds one entry and trades it with its neighbors.
// Depends on sle_pkg for the control struct and field widths.
`default_nettype none

module sle_cell #(
   parameter int IDX = 0,
   parameter int CW  = 7
) (
   input  wire logic                                clock,
   input  wire sle_pkg::cell_ctl_type              ctl,
   input  wire logic [CW-1:0]                      count,
   input  wire logic [CW-1:0]                      rem_start,
   input  wire logic signed [sle_pkg::VALUE_W-1:0] left_value,
   input  wire logic                                left_ge,
   input  wire logic signed [sle_pkg::VALUE_W-1:0] right_value,
   output logic signed [sle_pkg::VALUE_W-1:0]      value,
   output logic                                     ge
);

   localparam logic [CW-1:0] IDX_C = CW'(IDX);

   logic signed [sle_pkg::VALUE_W-1:0] value_ff;
   logic signed [sle_pkg::VALUE_W-1:0] value_in;
   logic                                occupied;

   assign occupied = IDX_C < count;
   // Entries are sorted, so this flag reads 0..0 1..1 along the occupied cells.
   assign ge       = occupied && (value_ff >= ctl.new_value);
   assign value    = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.ins_en) begin
         if (left_ge) begin
            value_in = left_value;
         end else if (ge || (IDX_C == count)) begin
            value_in = ctl.new_value;
         end
      end else if (ctl.rem_en) begin
         if (IDX_C >= rem_start) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

@@ sv/sle_read_tree.sv @@
// Registered OR tree that gathers the one selected cell value into a single word.
// Depends on sle_pkg for the value width; one register level per tree level.
`default_nettype none

module sle_read_tree #(
   parameter int LEAVES = 64
) (
   input  wire logic                                clock,
   input  wire logic [sle_pkg::VALUE_W-1:0]        leaf [LEAVES],
   output logic [sle_pkg::VALUE_W-1:0]             root
);

   logic [sle_pkg::VALUE_W-1:0] node_ff [1:LEAVES-1];

   for (genvar k = 1; k < LEAVES; k++) begin : g_node
      logic [sle_pkg::VALUE_W-1:0] lo_in;
      logic [sle_pkg::VALUE_W-1:0] hi_in;
      if (2 * k >= LEAVES) begin : g_leaf
         assign lo_in = leaf[2 * k - LEAVES];
         assign hi_in = leaf[2 * k + 1 - LEAVES];
      end else begin : g_inner
         assign lo_in = node_ff[2 * k];
         assign hi_in = node_ff[2 * k + 1];
      end
      always_ff @(posedge clock) begin
         node_ff[k] <= lo_in | hi_in;
      end
   end

   assign root = node_ff[1];

endmodule

`default_nettype wire

@@ sv/sle_checker.sv @@
// Port-level checks for the sorted list engine, bound to every instance of the top level.
// Depends on sle_pkg for status codes; sees only the ports of sorted_list_engine.
`default_nettype none

module sle_checker #(
   parameter int CAPACITY = 64
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic signed [sle_pkg::VALUE_W-1:0] rsp_read_value,
   input wire logic [sle_pkg::POS_W-1:0]          rsp_count,
   input wire logic [sle_pkg::STATUS_W-1:0]       rsp_status
);

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_count) && $stable(rsp_status))
      else $error("response changed while stalled");

   // Rejected commands never carry read data.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != sle_pkg::STATUS_OK) |-> rsp_read_value == '0)
      else $error("error response with nonzero read data");

   // A full error can only be reported when the list is at capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == sle_pkg::STATUS_FULL)
         |-> rsp_count == sle_pkg::POS_W'(CAPACITY))
      else $error("full status with count below capacity");

   // Status code three is never produced.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == sle_pkg::STATUS_OK) || (rsp_status == sle_pkg::STATUS_RANGE)
         || (rsp_status == sle_pkg::STATUS_FULL))
      else $error("undefined status code");

   // Reset empties the response register and the input stays open for a transaction.
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid && req_ready)
      else $error("response pending or input blocked after reset");

endmodule

bind sorted_list_engine sle_checker #(
   .CAPACITY (CAPACITY)
) u_sle_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_read_value (rsp_read_value),
   .rsp_count      (rsp_count),
   .rsp_status     (rsp_status)
);

`default_nettype wire
